// ===== hw/rtl/hvte_pkg.sv =====
// Shared types, character codes and keyword tables for the HTML text extractor.
// Used by the front classifier, the parser back end and the top level.
// No dependencies.
package hvte_pkg;

    localparam int BYTE_W = 8;
    localparam int NAME_LEN_W = 4;
    localparam int NUM_KW = 4;

    localparam int TAG_MATCH_LEN_DEF = 7;
    localparam int ITEM_QUEUE_DEPTH = 4;
    localparam int RESULT_QUEUE_DEPTH = 2;

    localparam logic [BYTE_W-1:0] CH_TAB = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_BANG = 8'h21;
    localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_AMP = 8'h26;
    localparam logic [BYTE_W-1:0] CH_DASH = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_SEMI = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_LT = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_GT = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'h20;

    // Keyword indexes
    localparam logic [1:0] KW_SCRIPT = 2'd0;
    localparam logic [1:0] KW_SCRIPT_END = 2'd1;
    localparam logic [1:0] KW_STYLE = 2'd2;
    localparam logic [1:0] KW_STYLE_END = 2'd3;

    // One classified byte, as it travels from front to back
    typedef struct packed {
        logic [BYTE_W-1:0] ch;       // byte with CR and LF folded to space
        logic [BYTE_W-1:0] upper;    // ASCII upper-case form of ch
        logic is_ws;
        logic is_lt;
        logic is_gt;
        logic is_amp;
        logic is_semi;
        logic is_quote;
        logic is_bslash;
        logic is_bang;
        logic is_dash;
    } item_t;

    localparam int ITEM_W = $bits(item_t);

    // Length of each keyword
    function automatic logic [NAME_LEN_W-1:0] kw_len(input logic [1:0] k);
        logic [NAME_LEN_W-1:0] len;
        begin
            case (k)
                KW_SCRIPT: len = 4'd6;
                KW_SCRIPT_END: len = 4'd7;
                KW_STYLE: len = 4'd5;
                KW_STYLE_END: len = 4'd6;
                default: len = 4'd0;
            endcase
            return len;
        end
    endfunction

    // Byte at position idx of keyword k; zero past the end
    function automatic logic [BYTE_W-1:0] kw_char(input logic [1:0] k,
                                                  input logic [2:0] idx);
        logic [7*BYTE_W-1:0] text;
        logic [BYTE_W-1:0] ch;
        begin
            case (k)
                KW_SCRIPT: text = {"SCRIPT", 8'h00};
                KW_SCRIPT_END: text = "/SCRIPT";
                KW_STYLE: text = {"STYLE", 16'h0000};
                KW_STYLE_END: text = {"/STYLE", 8'h00};
                default: text = '0;
            endcase
            case (idx)
                3'd0: ch = text[55:48];
                3'd1: ch = text[47:40];
                3'd2: ch = text[39:32];
                3'd3: ch = text[31:24];
                3'd4: ch = text[23:16];
                3'd5: ch = text[15:8];
                3'd6: ch = text[7:0];
                default: ch = 8'h00;
            endcase
            return ch;
        end
    endfunction

endpackage

// ===== hw/rtl/hvte_front.sv =====
// Front classifier: folds line breaks to space and flags every character
// class the parser looks at. Depends on hvte_pkg.
module hvte_front
(
    input  logic [hvte_pkg::BYTE_W-1:0] data_byte,
    output hvte_pkg::item_t             item
);
    import hvte_pkg::*;

    logic [BYTE_W-1:0] ch;

    // Fold CR and LF to space before anything else
    assign ch = (data_byte == CH_LF || data_byte == CH_CR) ? CH_SPACE : data_byte;

    // Classify the folded byte
    always_comb
    begin
        item.ch = ch;
        item.upper = (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) ? ch - CASE_OFFSET : ch;
        item.is_ws = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
        item.is_lt = (ch == CH_LT);
        item.is_gt = (ch == CH_GT);
        item.is_amp = (ch == CH_AMP);
        item.is_semi = (ch == CH_SEMI);
        item.is_quote = (ch == CH_QUOTE);
        item.is_bslash = (ch == CH_BSLASH);
        item.is_bang = (ch == CH_BANG);
        item.is_dash = (ch == CH_DASH);
    end

endmodule

// ===== hw/rtl/hvte_fifo.sv =====
// Small show-ahead queue in registers, used between front and back and on
// the result side. No package dependencies.
module hvte_fifo
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [AW:0] count_reg;
    logic [AW:0] count_next;
    logic do_wr;
    logic do_rd;

    assign full = (count_reg == (AW+1)'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Advance pointers, wrapping at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    // Hold the payload; no reset needed
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== hw/rtl/hvte_back.sv =====
// Parser back end: 13-state tag, comment and entity parser with script and
// style suppression and the tag-name keyword tracker. Depends on hvte_pkg.
module hvte_back
#(
    parameter int TAG_MATCH_LEN = hvte_pkg::TAG_MATCH_LEN_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  hvte_pkg::item_t             item,
    input  logic                        item_valid,
    output logic                        item_take,
    input  logic                        out_full,
    output logic                        out_wr,
    output logic [hvte_pkg::BYTE_W-1:0] out_data
);
    import hvte_pkg::*;

    localparam logic [3:0] S_CONTENT = 4'd0;
    localparam logic [3:0] S_AMP = 4'd1;
    localparam logic [3:0] S_SPACE = 4'd2;
    localparam logic [3:0] S_LT1 = 4'd3;
    localparam logic [3:0] S_LT2 = 4'd4;
    localparam logic [3:0] S_LT3 = 4'd5;
    localparam logic [3:0] S_NAME = 4'd6;
    localparam logic [3:0] S_TAG = 4'd7;
    localparam logic [3:0] S_COMMENT = 4'd8;
    localparam logic [3:0] S_CEND1 = 4'd9;
    localparam logic [3:0] S_CEND2 = 4'd10;
    localparam logic [3:0] S_TAG_QUOTE = 4'd11;
    localparam logic [3:0] S_CMT_QUOTE = 4'd12;

    localparam logic [NAME_LEN_W-1:0] NAME_SAT = NAME_LEN_W'(TAG_MATCH_LEN);

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic script_reg;
    logic script_next;
    logic style_reg;
    logic style_next;
    logic [NAME_LEN_W-1:0] name_len_reg;
    logic [NAME_LEN_W-1:0] name_len_next;
    logic [NUM_KW-1:0] alive_reg;
    logic [NUM_KW-1:0] alive_next;

    logic [NUM_KW-1:0] alive_pushed;
    logic [NAME_LEN_W-1:0] len_pushed;
    logic [NUM_KW-1:0] kw_hit;
    logic emit;
    logic hidden;

    // Take one item whenever the result side has room
    assign item_take = item_valid && !out_full;
    assign out_wr = item_take && emit;
    assign out_data = item.ch;
    assign hidden = script_reg || style_reg;

    // Name tracker after pushing the current byte
    always_comb
    begin
        for (int k = 0; k < NUM_KW; k++)
        begin
            alive_pushed[k] = alive_reg[k] &&
                !(name_len_reg >= kw_len(2'(k)) ||
                  kw_char(2'(k), name_len_reg[2:0]) != item.upper);
            kw_hit[k] = alive_reg[k] && (name_len_reg == kw_len(2'(k)));
        end
        len_pushed = (name_len_reg < NAME_SAT) ? name_len_reg + 1'b1 : name_len_reg;
    end

    // Parser next state
    always_comb
    begin
        state_next = state_reg;
        script_next = script_reg;
        style_next = style_reg;
        name_len_next = name_len_reg;
        alive_next = alive_reg;
        emit = 1'b0;
        case (state_reg)
            S_AMP:
            begin
                if (item.is_semi || item.is_ws)
                    state_next = S_CONTENT;
                else if (item.is_lt)
                    state_next = S_LT1;
            end
            S_SPACE:
            begin
                if (!item.is_ws)
                begin
                    if (item.is_lt)
                        state_next = S_LT1;
                    else if (item.is_amp)
                        state_next = S_AMP;
                    else
                    begin
                        emit = 1'b1;
                        state_next = S_CONTENT;
                    end
                end
            end
            S_LT1:
            begin
                if (item.is_quote)
                    state_next = S_TAG_QUOTE;
                else if (item.is_bang)
                    state_next = S_LT2;
                else if (item.is_gt)
                    state_next = S_CONTENT;
                else if (!item.is_bslash)
                begin
                    state_next = S_NAME;
                    alive_next = alive_pushed;
                    name_len_next = len_pushed;
                end
            end
            S_LT2, S_LT3:
            begin
                if (item.is_quote)
                    state_next = S_TAG_QUOTE;
                else if (item.is_dash)
                    state_next = (state_reg == S_LT2) ? S_LT3 : S_COMMENT;
                else if (item.is_gt)
                    state_next = S_CONTENT;
                else
                    state_next = S_TAG;
            end
            S_NAME, S_TAG:
            begin
                if (item.is_quote)
                    state_next = S_TAG_QUOTE;
                else if (item.is_gt)
                begin
                    // Close the tag: apply keyword effect, clear the name
                    state_next = S_CONTENT;
                    if (kw_hit[KW_SCRIPT])
                        script_next = 1'b1;
                    else if (kw_hit[KW_SCRIPT_END])
                        script_next = 1'b0;
                    else if (kw_hit[KW_STYLE])
                        style_next = 1'b1;
                    else if (kw_hit[KW_STYLE_END])
                        style_next = 1'b0;
                    name_len_next = '0;
                    alive_next = '1;
                end
                else if (state_reg == S_NAME)
                begin
                    if (item.is_ws)
                        state_next = S_TAG;
                    else
                    begin
                        alive_next = alive_pushed;
                        name_len_next = len_pushed;
                    end
                end
            end
            S_COMMENT:
            begin
                if (item.is_quote)
                    state_next = S_CMT_QUOTE;
                else if (item.is_dash)
                    state_next = S_CEND1;
            end
            S_CEND1:
            begin
                if (item.is_quote)
                    state_next = S_CMT_QUOTE;
                else
                    state_next = item.is_dash ? S_CEND2 : S_COMMENT;
            end
            S_CEND2:
            begin
                if (item.is_quote)
                    state_next = S_CMT_QUOTE;
                else
                    state_next = item.is_gt ? S_CONTENT : S_COMMENT;
            end
            S_TAG_QUOTE:
            begin
                if (item.is_quote)
                    state_next = S_TAG;
            end
            S_CMT_QUOTE:
            begin
                if (item.is_quote)
                    state_next = S_COMMENT;
            end
            default:
            begin
                // Content, and any unused code acts as content
                if (item.is_lt)
                    state_next = S_LT1;
                else if (!hidden)
                begin
                    if (item.is_ws)
                    begin
                        emit = 1'b1;
                        state_next = S_SPACE;
                    end
                    else if (item.is_amp)
                        state_next = S_AMP;
                    else
                    begin
                        emit = 1'b1;
                        state_next = S_CONTENT;
                    end
                end
                else
                    state_next = S_CONTENT;
            end
        endcase
    end

    // Update parser state only on a taken beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CONTENT;
            script_reg <= 1'b0;
            style_reg <= 1'b0;
            name_len_reg <= '0;
            alive_reg <= '1;
        end
        else if (item_take)
        begin
            state_reg <= state_next;
            script_reg <= script_next;
            style_reg <= style_next;
            name_len_reg <= name_len_next;
            alive_reg <= alive_next;
        end
    end

endmodule

// ===== hw/rtl/html_visible_text_extractor.sv =====
// HTML visible-text extractor: one raw byte in per beat, at most one text byte out.
// Throughput: one byte per cycle, stalled while the result queue is full.
// A pushed byte passes the item queue and the parser into the result queue.
// Reset (rst_n low, asynchronous): both queues empty, parser in content state,
// script and style flags cleared, name tracker cleared; ready in the next cycle.
module html_visible_text_extractor
#(
    parameter int TAG_MATCH_LEN = hvte_pkg::TAG_MATCH_LEN_DEF,
    parameter int ITEM_DEPTH = hvte_pkg::ITEM_QUEUE_DEPTH,
    parameter int RESULT_DEPTH = hvte_pkg::RESULT_QUEUE_DEPTH
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [hvte_pkg::BYTE_W-1:0] data_byte,
    output logic                        empty,
    input  logic                        pop,
    output logic [hvte_pkg::BYTE_W-1:0] text_byte
);
    import hvte_pkg::*;

    item_t front_item;
    item_t back_item;
    logic [ITEM_W-1:0] back_item_bits;
    logic item_empty;
    logic item_take;
    logic result_full;
    logic result_wr;
    logic [BYTE_W-1:0] result_data;

    // Classify incoming bytes
    hvte_front u_front
    (
        .data_byte (data_byte),
        .item      (front_item)
    );

    // Decouple front from parser
    hvte_fifo
    #(
        .WIDTH (ITEM_W),
        .DEPTH (ITEM_DEPTH)
    )
    u_item_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (front_item),
        .full    (full),
        .rd_en   (item_take),
        .rd_data (back_item_bits),
        .empty   (item_empty)
    );

    assign back_item = item_t'(back_item_bits);

    // Parse and select visible bytes
    hvte_back
    #(
        .TAG_MATCH_LEN (TAG_MATCH_LEN)
    )
    u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (back_item),
        .item_valid (!item_empty),
        .item_take  (item_take),
        .out_full   (result_full),
        .out_wr     (result_wr),
        .out_data   (result_data)
    );

    // Hold results until popped
    hvte_fifo
    #(
        .WIDTH (BYTE_W),
        .DEPTH (RESULT_DEPTH)
    )
    u_result_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (result_wr),
        .wr_data (result_data),
        .full    (result_full),
        .rd_en   (pop),
        .rd_data (text_byte),
        .empty   (empty)
    );

endmodule
